// ----- hdl/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and step tables for the MD5 digest core.
// ----------------------------------------------------------------------------
package md5_pkg;

    // four 32-bit words: A, B, C, D
    typedef logic [3:0][31:0] t_word4;

    // control from the sequencer to the step unit
    typedef struct packed {
        logic       load;   // copy the chaining words into the working words
        logic       run;    // perform one step
        logic [5:0] step;   // step number 0..63
    } t_step_ctl;

    localparam t_word4 MD5_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // message word index used by a step
    function automatic logic [3:0] md5_gidx(input logic [5:0] i);
        logic [7:0] t;
        begin
            case (i[5:4])
                2'd0: t = {4'd0, i[3:0]};
                2'd1: t = 8'd1 + 8'd5 * {4'd0, i[3:0]};
                2'd2: t = 8'd5 + 8'd3 * {4'd0, i[3:0]};
                default: t = 8'd7 * {4'd0, i[3:0]};
            endcase
            md5_gidx = t[3:0];
        end
    endfunction

    // rotate amount of a step
    function automatic logic [4:0] md5_rot(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0:  s = 5'd7;
                4'd1:  s = 5'd12;
                4'd2:  s = 5'd17;
                4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;
                4'd5:  s = 5'd9;
                4'd6:  s = 5'd14;
                4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;
                4'd9:  s = 5'd11;
                4'd10: s = 5'd16;
                4'd11: s = 5'd23;
                4'd12: s = 5'd6;
                4'd13: s = 5'd10;
                4'd14: s = 5'd15;
                default: s = 5'd21;
            endcase
            md5_rot = s;
        end
    endfunction

    // additive constant of a step (integer part of abs(sin(i+1)) * 2^32)
    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
            endcase
            md5_k = k;
        end
    endfunction

endpackage

// ----- hdl/md5_step.sv -----
// ----------------------------------------------------------------------------
// md5_step
// Working-word registers and the combinational MD5 step datapath.
// ----------------------------------------------------------------------------
module md5_step
    import md5_pkg::*;
(
    input  logic      i_clk,
    input  t_step_ctl i_ctl,
    input  t_word4    i_chain,
    input  logic [31:0] i_msg,
    output t_word4    o_work
);

    t_word4      r_work;
    t_word4      n_work;
    logic [31:0] a, b, c, d;
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot_wide;

    assign a = r_work[0];
    assign b = r_work[1];
    assign c = r_work[2];
    assign d = r_work[3];

    // round function
    always_comb begin
        case (i_ctl.step[5:4])
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
    end

    // add, rotate, add
    assign sum      = a + f + i_msg + md5_k(i_ctl.step);
    assign rot_wide = {sum, sum} << md5_rot(i_ctl.step);

    always_comb begin
        n_work = r_work;
        if (i_ctl.load) begin
            n_work = i_chain;
        end else if (i_ctl.run) begin
            n_work[0] = d;
            n_work[1] = rot_wide[63:32] + b;
            n_work[2] = b;
            n_work[3] = c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    assign o_work = r_work;

endmodule

// ----- hdl/md5_message_digest_core.sv -----
// ----------------------------------------------------------------------------
// md5_message_digest_core
// MD5 digest of a byte stream, at most one byte per accepted word.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the core collects, packed little-endian
// into a 16-word block memory. Each full 64-byte block then holds the input
// while the core primes the memory read and loads the working words, runs the
// 64 steps through the step unit (one memory read per step), and folds the
// result into the chaining words. On end_of_message the padding is written one
// memory word per cycle from the current word to word 15, followed by one
// compression, or two such passes when the tail leaves no room for the length.
// The four digest words are copied to an output buffer that drains on its own,
// so the next message can start while they wait.
// ----------------------------------------------------------------------------
module md5_message_digest_core
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_CPREP   = 3'd1;
    localparam logic [2:0] S_CSTEP   = 3'd2;
    localparam logic [2:0] S_FIN     = 3'd3;
    localparam logic [2:0] S_PSTART  = 3'd4;
    localparam logic [2:0] S_PAD     = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    function automatic logic [31:0] bswap(input logic [31:0] v);
        bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    logic [2:0]  r_state, n_state;
    logic [63:0] r_bit_count, n_bit_count;
    t_word4      r_chain, n_chain;
    logic [23:0] r_part, n_part;
    logic [5:0]  r_step, n_step;
    logic [3:0]  r_widx, n_widx;
    logic        r_pend_end, n_pend_end;
    logic        r_pad, n_pad;
    logic        r_spill, n_spill;
    logic        r_first, n_first;
    t_word4      r_dig, n_dig;
    logic        r_out_busy, n_out_busy;
    logic [1:0]  r_ocnt, n_ocnt;

    logic [31:0] r_buf [16];
    logic [31:0] r_rd_data;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  rd_addr;

    logic        in_acc;
    logic        out_acc;
    logic [1:0]  lane;
    t_step_ctl   step_ctl;
    t_word4      work;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign lane    = r_bit_count[4:3];
    assign o_stall = (r_state != S_COLLECT);

    // block memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[wr_addr] <= wr_data;
        end
        r_rd_data <= r_buf[rd_addr];
    end

    // prefetch the message word of the next step
    assign rd_addr = (r_state == S_CPREP) ? md5_gidx(6'd0) : md5_gidx(r_step + 6'd1);

    md5_step u_step (
        .i_clk   (i_clk),
        .i_ctl   (step_ctl),
        .i_chain (r_chain),
        .i_msg   (r_rd_data),
        .o_work  (work)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_bit_count = r_bit_count;
        n_chain     = r_chain;
        n_part      = r_part;
        n_step      = r_step;
        n_widx      = r_widx;
        n_pend_end  = r_pend_end;
        n_pad       = r_pad;
        n_spill     = r_spill;
        n_first     = r_first;
        n_dig       = r_dig;
        n_out_busy  = r_out_busy;
        n_ocnt      = r_ocnt;
        wr_en       = 1'b0;
        wr_addr     = r_bit_count[8:5];
        wr_data     = {i_data_byte, r_part};
        step_ctl    = '{load: 1'b0, run: 1'b0, step: r_step};

        // output buffer drain
        if (out_acc) begin
            if (r_ocnt == 2'd3) begin
                n_out_busy = 1'b0;
            end else begin
                n_ocnt = r_ocnt + 2'd1;
            end
        end

        case (r_state)
            S_COLLECT: begin
                if (in_acc) begin
                    if (i_byte_present) begin
                        n_bit_count = r_bit_count + 64'd8;
                        case (lane)
                            2'd0: n_part = {16'd0, i_data_byte};
                            2'd1: n_part[15:8] = i_data_byte;
                            2'd2: n_part[23:16] = i_data_byte;
                            default: wr_en = 1'b1;
                        endcase
                        if (r_bit_count[8:3] == 6'd63) begin
                            n_state    = S_CPREP;
                            n_pend_end = i_end_of_message;
                        end else if (i_end_of_message) begin
                            n_state = S_PSTART;
                        end
                    end else if (i_end_of_message) begin
                        n_state = S_PSTART;
                    end
                end
            end
            S_CPREP: begin
                step_ctl.load = 1'b1;
                n_step        = 6'd0;
                n_state       = S_CSTEP;
            end
            S_CSTEP: begin
                step_ctl.run = 1'b1;
                if (r_step == 6'd63) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            S_FIN: begin
                for (int k = 0; k < 4; k++) begin
                    n_chain[k] = r_chain[k] + work[k];
                end
                n_step = 6'd0;
                if (r_pad) begin
                    if (r_spill) begin
                        n_spill = 1'b0;
                        n_widx  = 4'd0;
                        n_first = 1'b0;
                        n_state = S_PAD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_pend_end) begin
                    n_state = S_PSTART;
                end else begin
                    n_state = S_COLLECT;
                end
            end
            S_PSTART: begin
                n_widx  = r_bit_count[8:5];
                n_spill = (r_bit_count[8:6] == 3'b111);
                n_first = 1'b1;
                n_pad   = 1'b1;
                n_state = S_PAD;
            end
            S_PAD: begin
                // pad word (first pass only), zeros, then the bit length in words 14 and 15 of the last block
                wr_en   = 1'b1;
                wr_addr = r_widx;
                if (r_first) begin
                    // a word with no bytes yet holds only the pad mark
                    wr_data = {8'd0, (lane == 2'd0) ? 24'd0 : r_part}
                            | ({24'd0, PAD_BYTE} << {lane, 3'b000});
                end else if (!r_spill && r_widx == 4'd14) begin
                    wr_data = r_bit_count[31:0];
                end else if (!r_spill && r_widx == 4'd15) begin
                    wr_data = r_bit_count[63:32];
                end else begin
                    wr_data = 32'd0;
                end
                n_first = 1'b0;
                if (r_widx == 4'd15) begin
                    n_state = S_CPREP;
                end else begin
                    n_widx = r_widx + 4'd1;
                end
            end
            S_DONE: begin
                if (!r_out_busy) begin
                    for (int k = 0; k < 4; k++) begin
                        n_dig[k] = bswap(r_chain[k]);
                    end
                    n_chain     = MD5_INIT;
                    n_bit_count = 64'd0;
                    n_pad       = 1'b0;
                    n_pend_end  = 1'b0;
                    n_out_busy  = 1'b1;
                    n_ocnt      = 2'd0;
                    n_state     = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_bit_count <= 64'd0;
            r_chain     <= MD5_INIT;
            r_step      <= 6'd0;
            r_pend_end  <= 1'b0;
            r_pad       <= 1'b0;
            r_spill     <= 1'b0;
            r_first     <= 1'b0;
            r_out_busy  <= 1'b0;
            r_ocnt      <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_bit_count <= n_bit_count;
            r_chain     <= n_chain;
            r_step      <= n_step;
            r_pend_end  <= n_pend_end;
            r_pad       <= n_pad;
            r_spill     <= n_spill;
            r_first     <= n_first;
            r_out_busy  <= n_out_busy;
            r_ocnt      <= n_ocnt;
        end
        r_part <= n_part;
        r_widx <= n_widx;
        r_dig  <= n_dig;
    end

    // output word
    assign o_valid       = r_out_busy;
    assign o_digest_word = r_dig[r_ocnt];
    assign o_word_index  = r_ocnt;
    assign o_last_word   = (r_ocnt == 2'd3);

    // the last digest word empties the output buffer
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_word) |=> !o_valid)
        else $error("output still valid after last digest word");

    // a new digest starts at word A
    a_digest_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_busy) |=> (o_valid && o_word_index == 2'd0))
        else $error("digest does not start at word A");

    // the final step is followed by the chain update
    a_step_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CSTEP && r_step == 6'd63) |=> (r_state == S_FIN))
        else $error("compression did not end after step 63");

    // no byte is taken while a block is being compressed
    a_no_input_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CPREP) |=> o_stall)
        else $error("input accepted during compression");

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MD5 message digest core.
// ----------------------------------------------------------------------------
// Byte words are fed in through the valid/stall input port. A behavioral MD5
// model runs on every accepted word and queues the four digest words that
// each end of message must produce. Output words are compared field by field
// against that queue. Directed messages cover the empty message, a byte
// arriving with its end mark, filler words and the padding block boundaries.
// Random messages with random content and lengths follow, under changing
// sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned QUIET_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES  = 300;
    localparam int unsigned ITEM_TARGET   = 420;
    localparam int unsigned DIGEST_TARGET = 48;
    localparam int unsigned FILLER_PCT    = 8;

    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [31:0] IV_A     = 32'h67452301;
    localparam logic [31:0] IV_B     = 32'hefcdab89;
    localparam logic [31:0] IV_C     = 32'h98badcfe;
    localparam logic [31:0] IV_D     = 32'h10325476;

    // rotate amounts, index = 4 * round + (step mod 4)
    localparam logic [15:0][4:0] ROT_AMT = {
        5'd21, 5'd15, 5'd10, 5'd6,
        5'd23, 5'd16, 5'd11, 5'd4,
        5'd20, 5'd14, 5'd9,  5'd5,
        5'd22, 5'd17, 5'd12, 5'd7
    };

    // digest of the empty message, used to sanity check the model
    localparam logic [127:0] EMPTY_DIGEST = 128'hd41d8cd98f00b204e9800998ecf8427e;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } t_digest;

    // dut ports
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte      = 8'h00;
    logic        i_byte_present   = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [31:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    // model state
    logic [31:0] hash_state [4];
    logic [7:0]  block_bytes [64];
    logic [63:0] msg_bit_len;
    logic [31:0] sine_k [64];

    t_digest     digest_queue [$];
    t_digest     head_digest;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned error_count    = 0;
    int unsigned items_sent     = 0;
    int unsigned messages_sent  = 0;
    int unsigned digests_queued = 0;
    int unsigned digests_seen   = 0;

    md5_message_digest_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // md5 model
    // ------------------------------------------------------------------

    // additive constants from the sine definition
    function automatic void build_sine_table();
        real s;
        int  i;
        for (i = 0; i < 64; i++) begin
            s = $sin(i + 1);
            if (s < 0.0)
                s = -s;
            sine_k[i] = 32'(longint'($floor(s * 4294967296.0)));
        end
    endfunction

    function automatic logic [31:0] rotate_left(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] byte_swap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic void restart_hash();
        hash_state[0] = IV_A;
        hash_state[1] = IV_B;
        hash_state[2] = IV_C;
        hash_state[3] = IV_D;
        msg_bit_len   = 64'd0;
    endfunction

    // 64 steps over the current block, then fold into the chain
    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, m, sum;
        int unsigned i, g, r;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        for (i = 0; i < 64; i++) begin
            r = i / 16;
            case (r)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (1 + 5 * i) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (5 + 3 * i) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            m = {block_bytes[4*g+3], block_bytes[4*g+2], block_bytes[4*g+1], block_bytes[4*g]};
            sum = a + f + m + sine_k[i];
            sum = rotate_left(sum, ROT_AMT[4 * r + i % 4]) + b;
            a = d;
            d = c;
            c = b;
            b = sum;
        end
        hash_state[0] = hash_state[0] + a;
        hash_state[1] = hash_state[1] + b;
        hash_state[2] = hash_state[2] + c;
        hash_state[3] = hash_state[3] + d;
    endfunction

    function automatic void absorb_byte(input logic [7:0] data);
        int unsigned pos;
        pos = 32'(msg_bit_len[8:3]);
        block_bytes[pos] = data;
        msg_bit_len = msg_bit_len + 64'd8;
        if (pos == 63)
            compress_block();
    endfunction

    // pad, append the length, compress and queue the four digest words
    function automatic void finish_message();
        int unsigned pos, k;
        t_digest     dw;
        pos = 32'(msg_bit_len[8:3]);
        block_bytes[pos] = PAD_MARK;
        for (k = pos + 1; k < 64; k++)
            block_bytes[k] = 8'h00;
        // no room for the length: spill into a second block
        if (pos >= 56) begin
            compress_block();
            for (k = 0; k < 64; k++)
                block_bytes[k] = 8'h00;
        end
        for (k = 0; k < 8; k++)
            block_bytes[56 + k] = msg_bit_len[8*k +: 8];
        compress_block();
        for (k = 0; k < 4; k++) begin
            dw.word  = byte_swap(hash_state[k]);
            dw.index = 2'(k);
            dw.last  = (k == 3);
            digest_queue.push_back(dw);
        end
        digests_queued += 4;
        restart_hash();
    endfunction

    // ------------------------------------------------------------------
    // handshake processes
    // ------------------------------------------------------------------

    // receiver stall
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // output check against the oldest queued digest word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            digests_seen++;
            if (digest_queue.size() == 0) begin
                $display("%0t: unexpected digest word %h index %0d last %0b",
                         $time, o_digest_word, o_word_index, o_last_word);
                error_count++;
            end else begin
                head_digest = digest_queue.pop_front();
                if (o_digest_word !== head_digest.word) begin
                    $display("%0t: digest_word expected %h actual %h",
                             $time, head_digest.word, o_digest_word);
                    error_count++;
                end
                if (o_word_index !== head_digest.index) begin
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, head_digest.index, o_word_index);
                    error_count++;
                end
                if (o_last_word !== head_digest.last) begin
                    $display("%0t: last_word expected %0b actual %0b",
                             $time, head_digest.last, o_last_word);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either port
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("[md5_message_digest_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct  = 62;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 62;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 19;
                recv_stall_pct = 19;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // drive one word and update the model once it is taken
    task automatic send_word(input logic [7:0] data, input logic present, input logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_data_byte      <= data;
        i_byte_present   <= present;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (present)
            absorb_byte(data);
        if (eom)
            finish_message();
        if (present || eom)
            items_sent++;
    endtask

    // message of random bytes with occasional filler words, end mark with the last byte or on its own
    task automatic send_message(input int unsigned len, input bit joined_end);
        int unsigned n;
        for (n = 0; n < len; n++) begin
            if ($urandom_range(99) < FILLER_PCT)
                send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            send_word(8'($urandom_range(255)), 1'b1, joined_end && (n == len - 1));
        end
        if (!joined_end || len == 0)
            send_word(8'($urandom_range(255)), 1'b0, 1'b1);
        messages_sent++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // end mark with no bytes at all
    task automatic test_empty_message();
        set_idling(IDLE_NONE);
        send_word(8'hff, 1'b0, 1'b1);
        messages_sent++;
        if ({digest_queue[0].word, digest_queue[1].word,
             digest_queue[2].word, digest_queue[3].word} !== EMPTY_DIGEST) begin
            $display("%0t: model empty digest expected %h actual %h%h%h%h", $time,
                     EMPTY_DIGEST, digest_queue[0].word, digest_queue[1].word,
                     digest_queue[2].word, digest_queue[3].word);
            error_count++;
        end
    endtask

    // single bytes at the extremes, filler words, separate end mark
    task automatic test_short_messages();
        set_idling(IDLE_NONE);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h55, 1'b0, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b0);
        send_word(8'haa, 1'b0, 1'b1);
        messages_sent += 3;
    endtask

    // lengths around the padding spill and the block edge
    task automatic test_block_boundaries();
        set_idling(IDLE_SENDER);
        send_message(55, 1'b1);
        set_idling(IDLE_RECEIVER);
        send_message(56, 1'b0);
        set_idling(IDLE_BOTH);
        send_message(63, 1'b0);
        set_idling(IDLE_NONE);
        send_message(64, 1'b1);
    endtask

    // mostly short messages, some spanning two or three blocks
    task automatic test_random_messages();
        int unsigned pick, len, count;
        count = 0;
        while (items_sent < ITEM_TARGET || digests_queued < DIGEST_TARGET) begin
            set_idling(t_idle_mode'(count % 4));
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(16, 0);
            else if (pick < 90)
                len = $urandom_range(70, 17);
            else
                len = $urandom_range(135, 60);
            send_message(len, 1'($urandom_range(1)));
            count++;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        build_sine_table();
        restart_hash();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_short_messages();
        test_block_boundaries();
        test_random_messages();

        // stop sending, then let the last digests drain
        @(negedge i_clk);
        i_valid <= 1'b0;
        set_idling(IDLE_NONE);
        while (digest_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d messages from %0d data and end words, %0d digest words checked",
                 messages_sent, items_sent, digests_seen);
        $display("including empty, single byte, padding spill and multi-block messages");
        if (error_count == 0 && digest_queue.size() == 0)
            $display("[md5_message_digest_core] OK");
        else
            $display("[md5_message_digest_core] ERROR");
        $finish;
    end

endmodule
